// ===== hdl/dpc_pkg.sv =====
// dpc_pkg: shared types, command and drive codes, register indexes and constants
// for the deadband position controller
// no dependencies; the design files refer to it by scoped names, the test files import it
package dpc_pkg;

  // command codes
  localparam logic [2:0] CMD_SET_REF = 3'd0;
  localparam logic [2:0] CMD_AUTO    = 3'd1;
  localparam logic [2:0] CMD_SEMI    = 3'd2;
  localparam logic [2:0] CMD_HOME    = 3'd3;
  localparam logic [2:0] CMD_HALT    = 3'd4;

  // drive codes
  localparam logic [1:0] DRV_NONE = 2'd0;
  localparam logic [1:0] DRV_FWD  = 2'd1;
  localparam logic [1:0] DRV_BACK = 2'd2;
  localparam logic [1:0] DRV_HALT = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_INVERTED_MOUNT  = 2'd0;
  localparam logic [1:0] REG_VIRTUAL_ENDSTOP = 2'd1;
  localparam logic [1:0] REG_DEADBAND        = 2'd2;
  localparam logic [1:0] REG_PERIOD_MS       = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // reset values of the registers
  localparam logic [9:0]  VEND_RESET     = 10'd923;
  localparam logic [9:0]  DEADBAND_RESET = 10'd10;
  localparam logic [15:0] PERIOD_RESET   = 16'd10;

  // mapping constants
  localparam logic [6:0]  PCT_FULL  = 7'd100;
  localparam logic [9:0]  POS_FRONT = 10'd923;   // fixed front reference of the mirrored map
  localparam logic [9:0]  POS_MAX   = 10'd1023;
  localparam logic [9:0]  POS_BASE  = 10'd100;

  // floor(p/100) for p in -10000..92300: bias by 10000, divide, remove 100
  localparam int                 PROD_W       = 17;
  localparam logic [19:0]        PROD_BIAS    = 20'd10000;
  localparam int                 RECIP_W      = 24;
  localparam logic [RECIP_W-1:0] DIV100_MUL   = 24'd10737419;  // ceil(2^30 / 100)
  localparam int                 DIV100_SHIFT = 30;
  localparam int                 QUOT_W       = 11;

  typedef struct packed {
    logic        inverted_mount;
    logic [9:0]  virtual_endstop;
    logic [9:0]  deadband;
    logic [15:0] period_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] ref_percent;
    logic [9:0]  position;
    logic [31:0] now_ms;
    logic        button_fwd;
    logic        button_back;
    logic        endstop_front;
    logic        endstop_rear;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         drive;
    logic signed [11:0] target;
  } out_word_t;

endpackage

// ===== hdl/dpc_ref_map.sv =====
// dpc_ref_map: front half of the reference mapping, saturates the percentage
// and forms the biased product of percentage and span
// depends on dpc_pkg
module dpc_ref_map (
  input  logic [15:0]                 percent,
  input  dpc_pkg::cfg_t               cfg,
  output logic [dpc_pkg::PROD_W-1:0]  prod_biased
);

  logic [6:0]         pct_sat;
  logic [6:0]         pct_eff;
  logic signed [11:0] span;
  logic signed [19:0] prod;
  logic signed [19:0] prod_off;

  always_comb begin
    pct_sat = (percent > {9'b0, dpc_pkg::PCT_FULL}) ? dpc_pkg::PCT_FULL : percent[6:0];
    if (cfg.inverted_mount) begin
      pct_eff = dpc_pkg::PCT_FULL - pct_sat;
      span    = $signed({2'b0, dpc_pkg::POS_FRONT}) - $signed({2'b0, cfg.virtual_endstop});
    end else begin
      pct_eff = pct_sat;
      span    = $signed({2'b0, cfg.virtual_endstop}) - $signed({2'b0, dpc_pkg::POS_BASE});
    end
    prod        = $signed({13'b0, pct_eff}) * $signed({{8{span[11]}}, span});
    // bias keeps the value non-negative so the divide can stay unsigned
    prod_off    = prod + $signed(dpc_pkg::PROD_BIAS);
    prod_biased = prod_off[dpc_pkg::PROD_W-1:0];
  end

endmodule

// ===== hdl/dpc_core.sv =====
// dpc_core: decision logic for one word, target update, timing check and drive
// selection between the input register and the result register
// depends on dpc_pkg
module dpc_core (
  input  dpc_pkg::in_word_t           word,
  input  logic [dpc_pkg::PROD_W-1:0]  prod_biased,
  input  dpc_pkg::cfg_t               cfg,
  input  logic [11:0]                 target_cur,
  input  logic [31:0]                 last_ms_cur,
  output logic [11:0]                 target_new,
  output logic [31:0]                 last_ms_new,
  output dpc_pkg::out_word_t          result
);

  logic [40:0]                 scaled;
  logic [dpc_pkg::QUOT_W-1:0]  quot;
  logic [12:0]                 mapped;
  logic [11:0]                 semi_target;
  logic [31:0]                 elapsed;
  logic                        due;
  logic signed [12:0]          err;
  logic [12:0]                 mag;
  logic [1:0]                  auto_drv;
  logic [1:0]                  home_drv;
  logic [1:0]                  drv;
  logic [11:0]                 tgt;
  logic                        timed;

  always_comb begin
    // divide by 100 through the reciprocal
    scaled = {24'b0, prod_biased} * {17'b0, dpc_pkg::DIV100_MUL};
    quot   = scaled[40:dpc_pkg::DIV100_SHIFT];
    if (cfg.inverted_mount) begin
      mapped = {3'b0, cfg.virtual_endstop} + {2'b0, quot} - {3'b0, dpc_pkg::POS_BASE};
    end else begin
      mapped = {2'b0, quot};
    end

    // button overwrites, back wins; only semi words look at the buttons
    semi_target = target_cur;
    if (word.command == dpc_pkg::CMD_SEMI) begin
      if (word.button_fwd) begin
        semi_target = {2'b0, cfg.virtual_endstop};
      end
      if (word.button_back) begin
        semi_target = cfg.inverted_mount ? {2'b0, dpc_pkg::POS_MAX} : 12'd0;
      end
    end

    elapsed = word.now_ms - last_ms_cur;
    due     = elapsed > {16'b0, cfg.period_ms};

    err = $signed({semi_target[11], semi_target}) - $signed({3'b0, word.position});
    mag = err[12] ? 13'(-err) : err;
    if (mag > {3'b0, cfg.deadband}) begin
      auto_drv = err[12] ? dpc_pkg::DRV_BACK : dpc_pkg::DRV_FWD;
    end else begin
      auto_drv = dpc_pkg::DRV_HALT;
    end

    if (cfg.inverted_mount) begin
      home_drv = word.endstop_front ? dpc_pkg::DRV_HALT : dpc_pkg::DRV_FWD;
    end else begin
      home_drv = word.endstop_rear ? dpc_pkg::DRV_HALT : dpc_pkg::DRV_BACK;
    end

    drv   = dpc_pkg::DRV_NONE;
    tgt   = target_cur;
    timed = 1'b0;
    case (word.command)
      dpc_pkg::CMD_SET_REF: begin
        tgt = mapped[11:0];
      end
      dpc_pkg::CMD_AUTO: begin
        timed = 1'b1;
        drv   = due ? auto_drv : dpc_pkg::DRV_NONE;
      end
      dpc_pkg::CMD_SEMI: begin
        timed = 1'b1;
        tgt   = semi_target;
        drv   = due ? auto_drv : dpc_pkg::DRV_NONE;
      end
      dpc_pkg::CMD_HOME: begin
        timed = 1'b1;
        drv   = due ? home_drv : dpc_pkg::DRV_NONE;
      end
      dpc_pkg::CMD_HALT: begin
        drv = dpc_pkg::DRV_HALT;
      end
      default: begin
        drv = dpc_pkg::DRV_NONE;
      end
    endcase

    target_new    = tgt;
    last_ms_new   = (timed && due) ? word.now_ms : last_ms_cur;
    result.drive  = drv;
    result.target = $signed(tgt);
  end

endmodule

// ===== hdl/deadband_position_controller.sv =====
// deadband_position_controller: top level, handshakes, configuration registers,
// input and result registers and controller state
// depends on dpc_pkg, dpc_ref_map and dpc_core
//
//   channel | port group                     | handshake
//   --------+--------------------------------+---------------------------
//   input   | in_valid, in_stall, in_word    | taken when valid & !stall
//   result  | out_valid, out_stall, out_word | taken when valid & !stall
//   config  | cfg_we, cfg_index, cfg_wdata   | written when cfg_we
//
// one word per cycle sustained while out_stall is low; a taken word is held in
// the input register, then in the result register that drives the result port,
// and can leave at the following edge at the earliest
// the percentage times span product is formed ahead of the input register,
// the divide by 100 and the decision follow it
// synchronous active-low reset clears target, timestamp, valids, presets config
// a stalled result holds; the input stalls only when both registers are full
module deadband_position_controller (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  dpc_pkg::in_word_t                in_word,
  output logic                             out_valid,
  input  logic                             out_stall,
  output dpc_pkg::out_word_t               out_word,
  input  logic                             cfg_we,
  input  logic [dpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dpc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // configuration
  dpc_pkg::cfg_t cfg_r;

  // input register
  logic                         s1_valid_r;
  dpc_pkg::in_word_t            s1_word_r;
  logic [dpc_pkg::PROD_W-1:0]   s1_prod_r;

  // result register
  logic                         out_valid_r;
  dpc_pkg::out_word_t           out_word_r;

  // controller state
  logic [11:0]                  target_r;
  logic [31:0]                  last_ms_r;

  logic [11:0]                  target_nxt;
  logic [31:0]                  last_ms_nxt;
  dpc_pkg::out_word_t           result_nxt;
  logic [dpc_pkg::PROD_W-1:0]   prod_nxt;

  logic                         s1_adv;
  logic                         in_take;

  // result register free or draining this cycle
  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // input word's product; user keeps config steady while words flow, unenforced
  dpc_ref_map u_ref_map (
    .percent     (in_word.ref_percent),
    .cfg         (cfg_r),
    .prod_biased (prod_nxt)
  );

  dpc_core u_core (
    .word        (s1_word_r),
    .prod_biased (s1_prod_r),
    .cfg         (cfg_r),
    .target_cur  (target_r),
    .last_ms_cur (last_ms_r),
    .target_new  (target_nxt),
    .last_ms_new (last_ms_nxt),
    .result      (result_nxt)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inverted_mount  <= 1'b0;
      cfg_r.virtual_endstop <= dpc_pkg::VEND_RESET;
      cfg_r.deadband        <= dpc_pkg::DEADBAND_RESET;
      cfg_r.period_ms       <= dpc_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dpc_pkg::REG_INVERTED_MOUNT:  cfg_r.inverted_mount  <= cfg_wdata[0];
        dpc_pkg::REG_VIRTUAL_ENDSTOP: cfg_r.virtual_endstop <= cfg_wdata[9:0];
        dpc_pkg::REG_DEADBAND:        cfg_r.deadband        <= cfg_wdata[9:0];
        dpc_pkg::REG_PERIOD_MS:       cfg_r.period_ms       <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv || !s1_valid_r) begin
      s1_valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word_r <= in_word;
      s1_prod_r <= prod_nxt;
    end
  end

  // result register and state, both move when the input register hands over
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      target_r    <= 12'd0;
      last_ms_r   <= 32'd0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        target_r  <= target_nxt;
        last_ms_r <= last_ms_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_word_r <= result_nxt;
    end
  end

  // halt always yields a halt result
  a_halt_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_adv && s1_word_r.command == dpc_pkg::CMD_HALT)
      |=> (out_valid_r && out_word_r.drive == dpc_pkg::DRV_HALT))
    else $error("halt word did not give a halt result");

  // state only moves when a word passes the decision logic
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_valid_r && s1_adv) |=> ($stable(target_r) && $stable(last_ms_r)))
    else $error("controller state changed without a word");

  // stored target stays within the converter range
  a_target_range: assert property (@(posedge clk) disable iff (!rst_n)
    target_r[11:10] == 2'b00)
    else $error("target left the position range");

  // input stalls only with both registers occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

endmodule

// ===== tb/drive_tracker_pkg.sv =====
// drive_tracker_pkg: mirror of the controller state that predicts each result word
// and checks the words that leave the block, in arrival order
// depends on dpc_pkg for the word types, command and drive codes and constants
package drive_tracker_pkg;
  import dpc_pkg::*;

  class drive_tracker;
    logic               mount_inverted;
    logic [9:0]         vend;
    logic [9:0]         dband;
    logic [15:0]        period;
    logic signed [11:0] target;
    logic [31:0]        last_ms;
    out_word_t          pending[$];
    int                 errors;
    int                 checked;

    function new();
      mount_inverted = 1'b0;
      vend           = VEND_RESET;
      dband          = DEADBAND_RESET;
      period         = PERIOD_RESET;
      target         = '0;
      last_ms        = '0;
      errors         = 0;
      checked        = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_INVERTED_MOUNT:  mount_inverted = val[0];
        REG_VIRTUAL_ENDSTOP: vend = val[9:0];
        REG_DEADBAND:        dband = val[9:0];
        REG_PERIOD_MS:       period = val;
        default: ;
      endcase
    endfunction

    function int pending_count();
      return pending.size();
    endfunction

    // rounds toward minus infinity
    function int div100_floor(int p);
      int q;
      q = p / 100;
      if (p < 0 && (p % 100) != 0) q = q - 1;
      return q;
    endfunction

    // true once more than the period has passed, modulo 2^32; claims the slot
    function bit take_slot(logic [31:0] now);
      logic [31:0] gap;
      gap = now - last_ms;
      if (gap > {16'd0, period}) begin
        last_ms = now;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function logic [1:0] steer_toward(logic [9:0] pos);
      int err;
      int mag;
      err = int'(target) - int'(pos);
      mag = (err < 0) ? -err : err;
      if (mag > int'(dband)) return (err < 0) ? DRV_BACK : DRV_FWD;
      return DRV_HALT;
    endfunction

    function void take_command(in_word_t w);
      out_word_t res;
      int        pct;
      int        v;
      v         = int'(vend);
      res.drive = DRV_NONE;
      case (w.command)
        CMD_SET_REF: begin
          pct = (w.ref_percent > PCT_FULL) ? int'(PCT_FULL) : int'(w.ref_percent);
          if (mount_inverted)
            target = 12'(v + div100_floor((int'(PCT_FULL) - pct) * (int'(POS_FRONT) - v)));
          else
            target = 12'(int'(POS_BASE) + div100_floor(pct * (v - int'(POS_BASE))));
        end
        CMD_AUTO: begin
          if (take_slot(w.now_ms)) res.drive = steer_toward(w.position);
        end
        CMD_SEMI: begin
          if (w.button_fwd) target = 12'(v);
          if (w.button_back) target = mount_inverted ? 12'(int'(POS_MAX)) : 12'd0;
          if (take_slot(w.now_ms)) res.drive = steer_toward(w.position);
        end
        CMD_HOME: begin
          if (take_slot(w.now_ms)) begin
            if (mount_inverted) res.drive = w.endstop_front ? DRV_HALT : DRV_FWD;
            else                res.drive = w.endstop_rear ? DRV_HALT : DRV_BACK;
          end
        end
        CMD_HALT: res.drive = DRV_HALT;
        default: ;
      endcase
      res.target = target;
      pending.push_back(res);
    endfunction

    function void check_drive(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        $error("result word with nothing pending: drive %0d target %0d", got.drive, got.target);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.drive !== want.drive) begin
        $error("drive: expected %0d, actual %0d", want.drive, got.drive);
        errors++;
      end
      if (got.target !== want.target) begin
        $error("target: expected %0d, actual %0d", want.target, got.target);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== tb/testbench.sv =====
// testbench: drives the deadband position controller through directed and random
// command words under several register settings, with stalls on both channels
// depends on dpc_pkg, drive_tracker_pkg and deadband_position_controller
module testbench;
  import dpc_pkg::*;
  import drive_tracker_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake
  localparam int LONG_HOLD      = 48;    // receiver hold-off, fills the pipeline
  localparam int PHASES         = 9;
  localparam int WORDS_PER_PHASE = 150;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_word_t   in_word = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_word;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  drive_tracker tracker;
  int           in_idle_pct = 0;     // chance of a gap before each command word
  int           out_idle_pct = 0;    // chance per cycle of a receiver stall burst
  bit           long_hold_req = 1'b0;
  int           hold_left = 0;
  int           quiet_cycles = 0;
  int           words_in = 0;
  int           settings_used = 0;
  logic [31:0]  clock_ms = '0;       // running millisecond clock for random words

  deadband_position_controller i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: checks each accepted result word, then decides the stall for the
  // next cycle; a requested long hold is counted out here, independent of the sender
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_drive(out_word);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (int'($urandom_range(0, 99)) < out_idle_pct) begin
      hold_left = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog: any handshake on either channel restarts the count
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("testbench failed");
      $finish;
    end
  end

  // offers one command word, with an optional idle burst first, and holds it
  // until the block takes it; the prediction is made at the accepting edge
  task automatic send_word(input in_word_t w);
    int gap;
    if (int'($urandom_range(0, 99)) < in_idle_pct) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    tracker.take_command(w);
    words_in++;
  endtask

  task automatic send_fields(input logic [2:0] cmd, input logic [15:0] pct,
                             input logic [9:0] pos, input logic [31:0] now,
                             input logic bf, input logic bb,
                             input logic ef, input logic er);
    in_word_t w;
    w.command       = cmd;
    w.ref_percent   = pct;
    w.position      = pos;
    w.now_ms        = now;
    w.button_fwd    = bf;
    w.button_back   = bb;
    w.endstop_front = ef;
    w.endstop_rear  = er;
    send_word(w);
  endtask

  task automatic wait_drained();
    while (tracker.pending_count() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    tracker.set_reg(idx, val);
  endtask

  // registers change only with the pipeline empty: the sender goes idle and every
  // pending result word is checked before the writes go in
  task automatic apply_setting(input logic inv, input logic [9:0] vend,
                               input logic [9:0] db, input logic [15:0] per);
    in_valid <= 1'b0;
    wait_drained();
    repeat (3) @(posedge clk);
    write_cfg(REG_INVERTED_MOUNT, {15'd0, inv});
    write_cfg(REG_VIRTUAL_ENDSTOP, {6'd0, vend});
    write_cfg(REG_DEADBAND, {6'd0, db});
    write_cfg(REG_PERIOD_MS, per);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // random command word: mostly drive steps with positions close to the target,
  // time moving forward around the period, now and then a jump or a wrap
  function automatic in_word_t random_word();
    in_word_t w;
    int       pick;
    int       near;
    int       db;
    pick = $urandom_range(0, 99);
    if (pick < 15)      w.command = CMD_SET_REF;
    else if (pick < 45) w.command = CMD_AUTO;
    else if (pick < 65) w.command = CMD_SEMI;
    else if (pick < 82) w.command = CMD_HOME;
    else if (pick < 95) w.command = CMD_HALT;
    else                w.command = 3'($urandom_range(5, 7));  // unused codes

    pick = $urandom_range(0, 9);
    if (pick < 5)      w.ref_percent = 16'($urandom_range(0, 100));
    else if (pick < 7) w.ref_percent = 16'($urandom_range(99, 120));
    else               w.ref_percent = 16'($urandom);

    db = int'(tracker.dband);
    if ($urandom_range(0, 9) < 6) begin
      // straddle the deadband edge
      near = int'(tracker.target) + int'($urandom_range(0, 2 * db + 6)) - (db + 3);
      if (near < 0) near = 0;
      if (near > 1023) near = 1023;
      w.position = 10'(near);
    end else begin
      w.position = 10'($urandom);
    end

    pick = $urandom_range(0, 99);
    if (pick < 80)      clock_ms = clock_ms + $urandom_range(0, 2 * int'(tracker.period) + 2);
    else if (pick < 90) clock_ms = $urandom;
    else if (pick < 95) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);  // close to the wrap
    w.now_ms = clock_ms;

    w.button_fwd    = ($urandom_range(0, 4) == 0);
    w.button_back   = ($urandom_range(0, 4) == 0);
    w.endstop_front = ($urandom_range(0, 2) == 0);
    w.endstop_rear  = ($urandom_range(0, 2) == 0);
    return w;
  endfunction

  initial begin
    logic        ph_inv;
    logic [9:0]  ph_vend;
    logic [9:0]  ph_db;
    logic [15:0] ph_per;

    tracker = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words at the reset settings: saturation, deadband edge, period
    // boundary, both buttons, homing, halt, unused codes and the time wrap
    send_fields(CMD_SET_REF, 16'd0,     10'd0,    32'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_fields(CMD_SET_REF, 16'd100,   10'd0,    32'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_fields(CMD_SET_REF, 16'd50,    10'd0,    32'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_fields(CMD_SET_REF, 16'd101,   10'd0,    32'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_fields(CMD_SET_REF, 16'hFFFF,  10'd0,    32'd0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_fields(CMD_AUTO,    16'd0,     10'd0,    32'd5, 1'b0, 1'b0, 1'b0, 1'b0);
    send_fields(CMD_AUTO,    16'd0,     10'd0,    32'd10, 1'b0, 1'b0, 1'b0, 1'b0);
    send_fields(CMD_AUTO,    16'd0,     10'd0,    32'd11, 1'b0, 1'b0, 1'b0, 1'b0);
    send_fields(CMD_AUTO,    16'd0,     10'd1023, 32'd100, 1'b0, 1'b0, 1'b0, 1'b0);
    send_fields(CMD_AUTO,    16'd0,     10'd913,  32'd200, 1'b0, 1'b0, 1'b0, 1'b0);
    send_fields(CMD_AUTO,    16'd0,     10'd912,  32'd300, 1'b0, 1'b0, 1'b0, 1'b0);
    send_fields(CMD_SEMI,    16'd0,     10'd500,  32'd301, 1'b1, 1'b1, 1'b0, 1'b0);
    send_fields(CMD_SEMI,    16'd0,     10'd923,  32'd400, 1'b1, 1'b0, 1'b0, 1'b0);
    send_fields(CMD_SEMI,    16'd0,     10'd0,    32'd500, 1'b0, 1'b0, 1'b0, 1'b0);
    send_fields(CMD_HOME,    16'd0,     10'd0,    32'd600, 1'b0, 1'b0, 1'b1, 1'b0);
    send_fields(CMD_HOME,    16'd0,     10'd0,    32'd700, 1'b0, 1'b0, 1'b0, 1'b1);
    send_fields(CMD_HOME,    16'd0,     10'd0,    32'd705, 1'b0, 1'b0, 1'b0, 1'b0);
    send_fields(CMD_HALT,    16'hFFFF,  10'h3FF,  32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1);
    send_fields(3'd5,        16'd7,     10'd1,    32'd800, 1'b1, 1'b0, 1'b0, 1'b0);
    send_fields(3'd6,        16'd7,     10'd1,    32'd900, 1'b0, 1'b1, 1'b0, 1'b0);
    send_fields(3'd7,        16'd7,     10'd1,    32'd1000, 1'b0, 1'b0, 1'b1, 1'b1);
    send_fields(CMD_AUTO,    16'd0,     10'd0,    32'hFFFF_FFF0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_fields(CMD_AUTO,    16'd0,     10'd0,    32'd3, 1'b0, 1'b0, 1'b0, 1'b0);

    // mirrored mount at the low end stop: mirrored mapping, back button to the
    // top and homing towards the front switch
    apply_setting(1'b1, 10'd0, 10'd0, 16'd0);
    send_fields(CMD_SET_REF, 16'd0,     10'd0,    32'd4, 1'b0, 1'b0, 1'b0, 1'b0);
    send_fields(CMD_SET_REF, 16'd33,    10'd0,    32'd4, 1'b0, 1'b0, 1'b0, 1'b0);
    send_fields(CMD_SEMI,    16'd0,     10'd1022, 32'd5, 1'b1, 1'b1, 1'b0, 1'b0);
    send_fields(CMD_HOME,    16'd0,     10'd0,    32'd6, 1'b0, 1'b0, 1'b0, 1'b1);
    send_fields(CMD_HOME,    16'd0,     10'd0,    32'd7, 1'b0, 1'b0, 1'b1, 1'b0);
    clock_ms = 32'd7;

    // random phases, one register setting each, extremes first
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin ph_inv = 1'b0; ph_vend = 10'd923;  ph_db = 10'd10;   ph_per = 16'd10;    end
        1: begin ph_inv = 1'b1; ph_vend = 10'd923;  ph_db = 10'd10;   ph_per = 16'd5;     end
        2: begin ph_inv = 1'b0; ph_vend = 10'd0;    ph_db = 10'd0;    ph_per = 16'd0;     end
        3: begin ph_inv = 1'b1; ph_vend = 10'd1023; ph_db = 10'd1023; ph_per = 16'hFFFF;  end
        4: begin ph_inv = 1'b1; ph_vend = 10'd0;    ph_db = 10'd5;    ph_per = 16'd1;     end
        5: begin ph_inv = 1'b0; ph_vend = 10'd1023; ph_db = 10'd1;    ph_per = 16'd100;   end
        6: begin ph_inv = 1'b0; ph_vend = 10'd99;   ph_db = 10'd20;   ph_per = 16'd3;     end
        default: begin
          ph_inv  = 1'($urandom_range(0, 1));
          ph_vend = 10'($urandom_range(0, 1023));
          ph_db   = 10'($urandom_range(0, 40));
          ph_per  = 16'($urandom_range(0, 40));
        end
      endcase
      apply_setting(ph_inv, ph_vend, ph_db, ph_per);

      // idling varies by phase; some phases run flat out, the last one too
      case (ph)
        1:       begin in_idle_pct = 0;  out_idle_pct = 0;  end
        5:       begin in_idle_pct = 0;  out_idle_pct = 20; end
        PHASES - 1: begin in_idle_pct = 0; out_idle_pct = 0; end
        default: begin
          in_idle_pct  = $urandom_range(10, 35);
          out_idle_pct = $urandom_range(10, 35);
        end
      endcase
      if (ph == 2) long_hold_req = 1'b1;  // sender keeps offering while held off

      repeat (WORDS_PER_PHASE) send_word(random_word());
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk);

    $display("%0d command words sent, %0d result words checked, %0d register settings",
             words_in, tracker.checked, settings_used);
    $display("all commands, saturated and mirrored targets, time wrap and long result stall");
    if (tracker.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
